// ===== rtl/core/zdd_membership_test_defines.svh =====
// Assertion macros shared by the diagram query RTL.
// They assume the module clock i_clk and the active-low reset i_rst_n.
`ifndef ZDD_MEMBERSHIP_TEST_DEFINES_SVH
`define ZDD_MEMBERSHIP_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZMT_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/zddmt_pkg.sv =====
package zddmt_pkg;

    localparam int NODE_W   = 12;
    localparam int LVL_W    = 7;
    localparam int LSTART_W = 13;
    localparam int ELEM_W   = 6;

    localparam logic [NODE_W-1:0] ROOT_NODE = 12'd2;
    localparam logic [NODE_W-1:0] TERM_ONE  = 12'd1;

    typedef enum logic [1:0] {
        OP_WR_NODE  = 2'd0,
        OP_WR_LEVEL = 2'd1,
        OP_QUERY    = 2'd2,
        OP_END      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EL_TEST,
        ST_EL_NODE,
        ST_ADV,
        ST_ADV_CMP,
        ST_POST,
        ST_EQ_TEST,
        ST_EQ_READ
    } t_state;

endpackage

// ===== rtl/core/zdd_membership_test.sv =====
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+-------------------------------------
// command  | in        | start high, busy low       | operation, node/level fields, element
// config   | in        | i_cfg_valid & o_cfg_ready  | level_count
// result   | out       | o_valid, one cycle         | is_member
//
// Table writes are taken only while idle. A query element walks each edge through the states
// EL_TEST, EL_NODE, ADV and POST, with ADV_CMP and ADV again per level boundary crossed.
// End query walks each lo edge down to a terminal through EQ_TEST and EQ_READ.
// Reset is synchronous and active low; the tables are not cleared and must be
// loaded. The receiver cannot stall: o_valid is high for exactly one cycle per result.
`include "zdd_membership_test_defines.svh"

module zdd_membership_test
    import zddmt_pkg::*;
#(
    parameter int MAX_NODES  = 4096,
    parameter int MAX_LEVELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [NODE_W-1:0]   i_node_index,
    input  logic [NODE_W-1:0]   i_lo_child,
    input  logic [NODE_W-1:0]   i_hi_child,
    input  logic [LVL_W-1:0]    i_level_index,
    input  logic [LSTART_W-1:0] i_level_first_node,
    input  logic [ELEM_W-1:0]   i_element,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LVL_W-1:0]    i_cfg_data,
    output logic                o_valid,
    output logic                o_is_member
);

    localparam int NAW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int XW     = NAW + NODE_W;
    localparam int STEP_W = $clog2(MAX_NODES + 1);
    localparam int LAW    = (MAX_LEVELS > 0) ? $clog2(MAX_LEVELS + 1) : 1;
    localparam int CW     = LAW + LVL_W;

    // Storage
    logic [2*NODE_W-1:0]  r_node_mem [MAX_NODES];
    logic [LSTART_W-1:0]  r_lvl_mem  [MAX_LEVELS+1];
    logic [2*NODE_W-1:0]  r_node_rd;
    logic [LSTART_W-1:0]  r_lvl_rd;

    // Control and walk state
    t_state               r_state, n_state;
    logic [NODE_W-1:0]    r_walk_node, n_walk_node;
    logic [LAW-1:0]       r_walk_level, n_walk_level;
    logic                 r_failed, n_failed;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic [ELEM_W-1:0]    r_elem, n_elem;
    logic                 r_take_hi, n_take_hi;
    logic                 r_rd_oor, n_rd_oor;
    logic [LVL_W-1:0]     r_level_count;
    logic                 r_out_valid, n_out_valid;
    logic                 r_is_member, n_is_member;

    // Memory controls
    logic                 node_we, node_re, lvl_we, lvl_re;
    logic [NAW-1:0]       node_waddr, node_raddr;
    logic [LAW-1:0]       lvl_waddr, lvl_raddr;

    // Shared decisions
    logic                 accept;
    t_op                  op;
    logic [XW-1:0]        wr_node_ext, walk_node_ext;
    logic [CW-1:0]        lidx_ext, lc_ext, used_ext, level_ext, elem_ext;
    logic                 wr_node_ok, walk_node_ok, lidx_ok;
    logic                 node_term, steps_max, level_gt, level_eq, level_lt_used;
    logic                 node_ge_start;
    logic [NODE_W-1:0]    rd_lo, rd_hi;

    assign accept        = start && !busy;
    assign op            = t_op'(i_operation);

    assign wr_node_ext   = {{NAW{1'b0}}, i_node_index};
    assign walk_node_ext = {{NAW{1'b0}}, r_walk_node};
    assign wr_node_ok    = wr_node_ext < XW'(MAX_NODES);
    assign walk_node_ok  = walk_node_ext < XW'(MAX_NODES);

    assign lidx_ext      = {{LAW{1'b0}}, i_level_index};
    assign lidx_ok       = lidx_ext <= CW'(MAX_LEVELS);
    assign lc_ext        = {{LAW{1'b0}}, r_level_count};
    assign used_ext      = (lc_ext > CW'(MAX_LEVELS)) ? CW'(MAX_LEVELS) : lc_ext;
    assign level_ext     = {{LVL_W{1'b0}}, r_walk_level};
    assign elem_ext      = CW'(r_elem);

    assign node_term     = r_walk_node < ROOT_NODE;
    assign steps_max     = r_steps == STEP_W'(MAX_NODES);
    assign level_gt      = level_ext > elem_ext;
    assign level_eq      = level_ext == elem_ext;
    assign level_lt_used = level_ext < used_ext;
    assign node_ge_start = {1'b0, r_walk_node} >= r_lvl_rd;

    assign rd_lo         = r_node_rd[NODE_W-1:0];
    assign rd_hi         = r_node_rd[2*NODE_W-1:NODE_W];

    assign node_waddr    = wr_node_ext[NAW-1:0];
    assign node_raddr    = walk_node_ext[NAW-1:0];
    assign lvl_waddr     = lidx_ext[LAW-1:0];
    assign lvl_raddr     = r_walk_level + LAW'(1);

    assign busy          = r_state != ST_IDLE;
    assign o_cfg_ready   = r_state == ST_IDLE;
    assign o_valid       = r_out_valid;
    assign o_is_member   = r_is_member;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !r_failed) begin
                    if (op == OP_QUERY && !node_term) begin
                        n_state = ST_EL_TEST;
                    end else if (op == OP_END) begin
                        n_state = ST_EQ_TEST;
                    end
                end
            end
            ST_EL_TEST: begin
                n_state = (steps_max || level_gt) ? ST_IDLE : ST_EL_NODE;
            end
            ST_EL_NODE: begin
                n_state = ST_ADV;
            end
            ST_ADV: begin
                n_state = level_lt_used ? ST_ADV_CMP : ST_POST;
            end
            ST_ADV_CMP: begin
                n_state = node_ge_start ? ST_ADV : ST_POST;
            end
            ST_POST: begin
                n_state = (r_take_hi || node_term) ? ST_IDLE : ST_EL_TEST;
            end
            ST_EQ_TEST: begin
                n_state = (node_term || steps_max) ? ST_IDLE : ST_EQ_READ;
            end
            ST_EQ_READ: begin
                n_state = ST_EQ_TEST;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_walk_node  = r_walk_node;
        n_walk_level = r_walk_level;
        n_failed     = r_failed;
        n_steps      = r_steps;
        n_elem       = r_elem;
        n_take_hi    = r_take_hi;
        n_rd_oor     = r_rd_oor;
        n_out_valid  = 1'b0;
        n_is_member  = r_is_member;
        node_we      = 1'b0;
        node_re      = 1'b0;
        lvl_we       = 1'b0;
        lvl_re       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_WR_NODE: begin
                            node_we = wr_node_ok;
                        end
                        OP_WR_LEVEL: begin
                            lvl_we = lidx_ok;
                        end
                        OP_QUERY: begin
                            if (!r_failed) begin
                                n_failed = node_term;
                                n_elem   = i_element;
                                n_steps  = '0;
                            end
                        end
                        OP_END: begin
                            n_steps = '0;
                            if (r_failed) begin
                                n_out_valid  = 1'b1;
                                n_is_member  = 1'b0;
                                n_walk_node  = ROOT_NODE;
                                n_walk_level = '0;
                                n_failed     = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EL_TEST: begin
                if (steps_max || level_gt) begin
                    n_failed = 1'b1;
                end else begin
                    node_re   = 1'b1;
                    n_rd_oor  = !walk_node_ok;
                    n_take_hi = level_eq;
                end
            end
            ST_EL_NODE: begin
                if (r_rd_oor) begin
                    n_walk_node = '0;
                end else begin
                    n_walk_node = r_take_hi ? rd_hi : rd_lo;
                end
            end
            ST_ADV: begin
                lvl_re = level_lt_used;
            end
            ST_ADV_CMP: begin
                if (node_ge_start) begin
                    n_walk_level = r_walk_level + LAW'(1);
                end
            end
            ST_POST: begin
                if (!r_take_hi) begin
                    if (node_term) begin
                        n_failed = 1'b1;
                    end else begin
                        n_steps = r_steps + STEP_W'(1);
                    end
                end
            end
            ST_EQ_TEST: begin
                if (node_term || steps_max) begin
                    n_out_valid  = 1'b1;
                    n_is_member  = r_walk_node == TERM_ONE;
                    n_walk_node  = ROOT_NODE;
                    n_walk_level = '0;
                    n_failed     = 1'b0;
                end else begin
                    node_re  = 1'b1;
                    n_rd_oor = !walk_node_ok;
                end
            end
            ST_EQ_READ: begin
                n_walk_node = r_rd_oor ? '0 : rd_lo;
                n_steps     = r_steps + STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_walk_node   <= ROOT_NODE;
            r_walk_level  <= '0;
            r_failed      <= 1'b0;
            r_steps       <= '0;
            r_out_valid   <= 1'b0;
            r_level_count <= '0;
        end else begin
            r_state      <= n_state;
            r_walk_node  <= n_walk_node;
            r_walk_level <= n_walk_level;
            r_failed     <= n_failed;
            r_steps      <= n_steps;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_level_count <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_elem      <= n_elem;
        r_take_hi   <= n_take_hi;
        r_rd_oor    <= n_rd_oor;
        r_is_member <= n_is_member;
    end

    // Node table: lo child in the low half, hi child in the high half.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= {i_hi_child, i_lo_child};
        end
        if (node_re) begin
            r_node_rd <= r_node_mem[node_raddr];
        end
    end

    // Level start table.
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_waddr] <= i_level_first_node;
        end
        if (lvl_re) begin
            r_lvl_rd <= r_lvl_mem[lvl_raddr];
        end
    end

    `ZMT_ASSERT_HOLDS(a_write_when_idle, node_we || lvl_we, r_state == ST_IDLE, "write in walk")
    `ZMT_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe held over two cycles")
    `ZMT_ASSERT_HOLDS(a_level_bound, 1'b1, r_walk_level <= LAW'(MAX_LEVELS), "level overflow")
    `ZMT_ASSERT_HOLDS(a_cmp_read, r_state == ST_ADV_CMP, $past(r_state) == ST_ADV, "no level read")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import zddmt_pkg::*;

    localparam int NODE_SPAN     = 4096;
    localparam int LEVEL_SPAN    = 64;
    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 100;
    localparam int CYCLE_LIMIT   = 4000000;

    typedef enum bit {WORD_CMD, WORD_CFG} t_word_kind;

    typedef struct {
        t_word_kind          kind;
        bit                  drain;
        int                  gap;
        t_op                 op;
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   lo;
        logic [NODE_W-1:0]   hi;
        logic [LVL_W-1:0]    lidx;
        logic [LSTART_W-1:0] lfirst;
        logic [ELEM_W-1:0]   elem;
        logic [LVL_W-1:0]    cfg_value;
    } t_zdd_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_operation = '0;
    logic [NODE_W-1:0]   i_node_index = '0;
    logic [NODE_W-1:0]   i_lo_child = '0;
    logic [NODE_W-1:0]   i_hi_child = '0;
    logic [LVL_W-1:0]    i_level_index = '0;
    logic [LSTART_W-1:0] i_level_first_node = '0;
    logic [ELEM_W-1:0]   i_element = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LVL_W-1:0]    i_cfg_data = '0;
    logic                o_valid;
    logic                o_is_member;

    zdd_membership_test uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_node_index       (i_node_index),
        .i_lo_child         (i_lo_child),
        .i_hi_child         (i_hi_child),
        .i_level_index      (i_level_index),
        .i_level_first_node (i_level_first_node),
        .i_element          (i_element),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_is_member        (o_is_member)
    );

    always #1 i_clk = ~i_clk;

    // Diagram as the block should hold it, plus the walk of the open query.
    logic [NODE_W-1:0]   node_lo [0:NODE_SPAN-1];
    logic [NODE_W-1:0]   node_hi [0:NODE_SPAN-1];
    logic [LSTART_W-1:0] level_base [0:LEVEL_SPAN];
    logic [LVL_W-1:0]    cfg_levels = '0;
    logic [NODE_W-1:0]   walk_at = ROOT_NODE;
    logic [LVL_W-1:0]    walk_depth = '0;
    bit                  query_dead = 1'b0;

    bit        member_expect [$];
    t_zdd_word cmd_backlog [$];
    int        mismatches = 0;
    int        cycle_count = 0;

    // Plan of the diagram currently loaded, used to build queries that walk deep.
    int plan_lo [0:NODE_SPAN-1];
    int plan_hi [0:NODE_SPAN-1];
    int plan_level [0:NODE_SPAN-1];
    bit plan_used [0:NODE_SPAN-1];
    int plan_ids [$];
    int words_planned = 0;
    bit hold_next = 1'b0;
    bit quiet_gaps = 1'b0;

    function automatic void climb_levels();
        int used;
        used = (int'(cfg_levels) > LEVEL_SPAN) ? LEVEL_SPAN : int'(cfg_levels);
        while (walk_depth < used && {1'b0, walk_at} >= level_base[walk_depth + 1])
            walk_depth++;
    endfunction

    function automatic void walk_element(logic [ELEM_W-1:0] elem);
        int steps;
        if (query_dead)
            return;
        if (walk_at <= TERM_ONE) begin
            query_dead = 1'b1;
            return;
        end
        for (steps = 0; steps < NODE_SPAN; steps++) begin
            if (walk_depth > elem) begin
                query_dead = 1'b1;
                return;
            end
            if (walk_depth == elem) begin
                walk_at = node_hi[walk_at];
                climb_levels();
                return;
            end
            walk_at = node_lo[walk_at];
            climb_levels();
            if (walk_at <= TERM_ONE) begin
                query_dead = 1'b1;
                return;
            end
        end
        // A lo cycle that never reaches the element's level.
        query_dead = 1'b1;
    endfunction

    function automatic bit close_query();
        logic [NODE_W-1:0] n;
        int                steps;
        bit                found;
        n = walk_at;
        steps = 0;
        found = 1'b0;
        if (!query_dead) begin
            while (n > TERM_ONE && steps < NODE_SPAN) begin
                n = node_lo[n];
                steps++;
            end
            found = (n == TERM_ONE);
        end
        walk_at = ROOT_NODE;
        walk_depth = '0;
        query_dead = 1'b0;
        return found;
    endfunction

    function automatic void track_command(t_zdd_word w);
        case (w.op)
            OP_WR_NODE: begin
                node_lo[w.node] = w.lo;
                node_hi[w.node] = w.hi;
            end
            OP_WR_LEVEL: begin
                if (w.lidx <= LEVEL_SPAN)
                    level_base[w.lidx] = w.lfirst;
            end
            OP_QUERY: walk_element(w.elem);
            OP_END: member_expect.insert(member_expect.size(), close_query());
        endcase
    endfunction

    task automatic flag_mismatch(string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int roll;
        if (quiet_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_zdd_word random_word();
        t_zdd_word w;
        w.kind = WORD_CMD;
        w.drain = 1'b0;
        w.gap = 0;
        w.op = t_op'($urandom_range(0, 3));
        w.node = NODE_W'($urandom);
        w.lo = NODE_W'($urandom);
        w.hi = NODE_W'($urandom);
        w.lidx = LVL_W'($urandom);
        w.lfirst = LSTART_W'($urandom);
        w.elem = ELEM_W'($urandom);
        w.cfg_value = LVL_W'($urandom);
        return w;
    endfunction

    task automatic queue_word(t_zdd_word w);
        w.gap = pick_gap();
        w.drain = w.drain | hold_next;
        hold_next = 1'b0;
        cmd_backlog.insert(cmd_backlog.size(), w);
        if (w.kind == WORD_CMD)
            words_planned++;
    endtask

    task automatic push_node(int id, int lo, int hi);
        t_zdd_word w;
        w = random_word();
        w.op = OP_WR_NODE;
        w.node = NODE_W'(id);
        w.lo = NODE_W'(lo);
        w.hi = NODE_W'(hi);
        queue_word(w);
    endtask

    task automatic push_level(int idx, int first);
        t_zdd_word w;
        w = random_word();
        w.op = OP_WR_LEVEL;
        w.lidx = LVL_W'(idx);
        w.lfirst = LSTART_W'(first);
        queue_word(w);
    endtask

    task automatic push_element(int e);
        t_zdd_word w;
        w = random_word();
        w.op = OP_QUERY;
        w.elem = ELEM_W'(e);
        queue_word(w);
    endtask

    task automatic push_end();
        t_zdd_word w;
        w = random_word();
        w.op = OP_END;
        queue_word(w);
    endtask

    task automatic push_cfg(int value);
        t_zdd_word w;
        w = random_word();
        w.kind = WORD_CFG;
        w.drain = 1'b1;
        w.cfg_value = LVL_W'(value);
        queue_word(w);
    endtask

    function automatic int pick_child(int from_idx);
        int last;
        if (from_idx >= plan_ids.size() || $urandom_range(0, 3) == 0)
            return ($urandom_range(0, 4) == 0) ? 0 : 1;
        last = from_idx + 3;
        if (last > plan_ids.size() - 1)
            last = plan_ids.size() - 1;
        return plan_ids[$urandom_range(from_idx, last)];
    endfunction

    // Lays out an acyclic diagram: ids grow with the level, children sit on deeper levels.
    // Spread layouts leave wide holes between levels so that ids reach the top of the range.
    task automatic build_diagram(int levels);
        int first_of [0:LEVEL_SPAN];
        int idx_end [0:LEVEL_SPAN-1];
        int cur, cnt, room, k, i, n, rot;
        bit spread;
        foreach (plan_ids[j])
            plan_used[plan_ids[j]] = 1'b0;
        plan_ids.delete();
        spread = ($urandom_range(0, 3) == 0);
        cur = ROOT_NODE;
        for (k = 0; k < levels; k++) begin
            first_of[k] = cur;
            cnt = (k == 0) ? $urandom_range(1, 3) : $urandom_range(0, (levels > 16) ? 2 : 3);
            for (i = 0; i < cnt; i++) begin
                plan_ids.insert(plan_ids.size(), cur + i);
                plan_level[cur + i] = k;
                plan_used[cur + i] = 1'b1;
            end
            idx_end[k] = plan_ids.size();
            cur += cnt;
            room = NODE_SPAN - cur - 3 * (levels - 1 - k);
            if (spread && room > 0)
                cur += $urandom_range(0, (k == levels - 1) ? room : room / 2);
            else if (!spread && room > 2)
                cur += $urandom_range(0, 2);
        end
        first_of[levels] = cur;
        for (i = 0; i < plan_ids.size(); i++) begin
            n = plan_ids[i];
            plan_lo[n] = pick_child(idx_end[plan_level[n]]);
            plan_hi[n] = pick_child(idx_end[plan_level[n]]);
        end
        if ($urandom_range(0, 3) == 0)
            push_level(0, ROOT_NODE);
        for (k = 1; k <= levels; k++)
            push_level(k, first_of[k]);
        if ($urandom_range(0, 3) == 0)
            push_level($urandom_range(LEVEL_SPAN + 1, 127), $urandom_range(0, 8191));
        rot = $urandom_range(0, plan_ids.size() - 1);
        for (i = 0; i < plan_ids.size(); i++) begin
            n = plan_ids[(rot + i) % plan_ids.size()];
            push_node(n, plan_lo[n], plan_hi[n]);
        end
    endtask

    // Most sets follow a random path through the loaded diagram; the rest are
    // damaged paths, random ascending sets and plain noise.
    task automatic run_query(int levels);
        int elems [$];
        int n, k, roll, id;
        quiet_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 29) == 0)
            hold_next = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            n = ROOT_NODE;
            while (n > TERM_ONE) begin
                if ($urandom_range(0, 1) == 1) begin
                    elems.insert(elems.size(), plan_level[n]);
                    n = plan_hi[n];
                end else begin
                    n = plan_lo[n];
                end
            end
            if (roll >= 63) begin
                if (elems.size() > 0 && $urandom_range(0, 1) == 1)
                    elems.delete($urandom_range(0, elems.size() - 1));
                else
                    elems.insert(elems.size(), $urandom_range(0, 63));
            end
        end else if (roll < 88) begin
            for (k = 0; k < levels; k++)
                if ($urandom_range(0, 2) == 0)
                    elems.insert(elems.size(), k);
        end else begin
            repeat ($urandom_range(0, 5))
                elems.insert(elems.size(), $urandom_range(0, 63));
        end
        foreach (elems[i]) begin
            push_element(elems[i]);
            // A write to a node outside the diagram must not disturb the open query.
            if ($urandom_range(0, 24) == 0) begin
                id = $urandom_range(0, NODE_SPAN - 1);
                if (!plan_used[id])
                    push_node(id, $urandom, $urandom);
            end
        end
        push_end();
        quiet_gaps = 1'b0;
    endtask

    t_zdd_word held_word;
    t_zdd_word live_word;
    bit        word_held = 1'b0;
    bit        word_live = 1'b0;
    int        gap_left = 0;
    int        settle_left = 0;

    always @(posedge i_clk) begin : word_driver
        logic next_start;
        logic next_cfg_valid;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            word_held = 1'b0;
            word_live = 1'b0;
            walk_at = ROOT_NODE;
            walk_depth = '0;
            query_dead = 1'b0;
            cfg_levels = '0;
        end else begin
            next_start = start;
            next_cfg_valid = i_cfg_valid;
            if (start && !busy) begin
                track_command(live_word);
                next_start = 1'b0;
                word_live = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_levels = live_word.cfg_value;
                next_cfg_valid = 1'b0;
                word_live = 1'b0;
            end
            if (!word_live) begin
                if (!word_held && cmd_backlog.size() != 0) begin
                    held_word = cmd_backlog.pop_front();
                    word_held = 1'b1;
                    gap_left = held_word.gap;
                    settle_left = SETTLE_CYCLES;
                end
                if (word_held) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (held_word.drain && (member_expect.size() != 0 || busy)) begin
                        settle_left = SETTLE_CYCLES;
                    end else if (held_word.drain && settle_left != 0) begin
                        settle_left--;
                    end else begin
                        live_word = held_word;
                        word_held = 1'b0;
                        word_live = 1'b1;
                        i_operation <= held_word.op;
                        i_node_index <= held_word.node;
                        i_lo_child <= held_word.lo;
                        i_hi_child <= held_word.hi;
                        i_level_index <= held_word.lidx;
                        i_level_first_node <= held_word.lfirst;
                        i_element <= held_word.elem;
                        i_cfg_data <= held_word.cfg_value;
                        if (held_word.kind == WORD_CFG)
                            next_cfg_valid = 1'b1;
                        else
                            next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
            i_cfg_valid <= next_cfg_valid;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        bit want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (member_expect.size() == 0) begin
                flag_mismatch($sformatf("membership word %b with none pending", o_is_member));
            end else begin
                want = member_expect.pop_front();
                if (o_is_member !== want)
                    flag_mismatch($sformatf("is_member %b, predicted %b", o_is_member, want));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int k, lc, levels, phase;
        // Directed: three levels, root 2; level 1 holds nodes 3 and 4, level 2 node 4095.
        push_cfg(3);
        for (k = 0; k <= LEVEL_SPAN; k++)
            push_level(k, NODE_SPAN);
        push_level(1, 3);
        push_level(2, 5);
        push_node(2, 3, 4);
        push_node(3, 0, 4095);
        push_node(4, 1, 4095);
        push_node(4095, 0, 1);
        push_level(127, 0);
        // Empty set ends on the 0-terminal.
        push_end();
        // Full path ending on the 1-terminal.
        push_element(0);
        push_element(1);
        push_element(2);
        push_end();
        // Lo walk hits a terminal early; the element after it is ignored.
        push_element(2);
        push_element(1);
        push_end();
        // Descending elements: level already passed.
        push_element(1);
        push_element(0);
        push_end();
        // Element left over after the 1-terminal was reached.
        push_element(0);
        push_element(1);
        push_element(2);
        push_element(63);
        push_end();
        // Self loop on the root: both walks give up after the step bound.
        push_node(2, 2, 3);
        push_end();
        push_element(5);
        push_end();

        phase = 0;
        while (words_planned < ITEM_TARGET) begin
            case (phase)
                0: lc = LEVEL_SPAN;
                1: lc = 0;
                2: lc = 127;
                3: lc = $urandom_range(33, 63);
                default: lc = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 32)
                                                          : $urandom_range(1, 8);
            endcase
            push_cfg(lc);
            levels = (lc == 0) ? 1 : ((lc > LEVEL_SPAN) ? LEVEL_SPAN : lc);
            repeat ((levels > 16) ? 1 : $urandom_range(2, 3)) begin
                build_diagram(levels);
                repeat ((levels > 16) ? $urandom_range(4, 8) : $urandom_range(6, 14))
                    run_query(levels);
            end
            phase++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_backlog.size() != 0 || word_held || word_live || member_expect.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
